// ===== rtl/sorted_distance_entry_table_defines.svh =====
// Assertion macros used by the controller of the sorted distance entry table RTL.
`ifndef SORTED_DISTANCE_ENTRY_TABLE_DEFINES_SVH
`define SORTED_DISTANCE_ENTRY_TABLE_DEFINES_SVH

// Checks an implication in the same cycle, clocked on clk_i and quiet in reset.
`define SDET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks an implication in the following cycle, clocked on clk_i and quiet in reset.
`define SDET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sdet_pkg.sv =====
// Types and constants of the sorted distance entry table.
`default_nettype none

package sdet_pkg;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_POP    = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_ROOM = 2'd1;
  localparam logic [1:0] STATUS_BAD_IDX = 2'd2;

  localparam logic [1:0] CFG_PAGE_SIZE      = 2'd0;
  localparam logic [1:0] CFG_ENTRY_OVERHEAD = 2'd1;
  localparam logic [1:0] CFG_BASE_OVERHEAD  = 2'd2;

  localparam logic [15:0] PAGE_SIZE_RST      = 16'd4096;
  localparam logic [7:0]  ENTRY_OVERHEAD_RST = 8'd8;
  localparam logic [9:0]  BASE_OVERHEAD_RST  = 10'd16;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] distance;
    logic [15:0] object_id;
    logic [15:0] object_size;
    logic [3:0]  index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_object;
    logic [31:0] out_distance;
    logic [4:0]  entry_count;
    logic [15:0] used_bytes;
  } res_t;

  typedef struct packed {
    logic [15:0] page_size;
    logic [7:0]  entry_overhead;
    logic [9:0]  base_overhead;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic check;
    logic update;
  } ctrl_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_UPDATE
  } state_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_DELETE
  } act_e;

endpackage

`default_nettype wire

// ===== rtl/sorted_distance_entry_table.sv =====
// Top level of the sorted distance entry table.
`default_nettype none
// Keeps up to MAX_ENTRIES entries (handle, distance, size) sorted by ascending
// distance under a page byte budget, with add, remove at index and pop.
// A request on req_i is taken at a rising edge where start is high and
// busy is low. The block then runs a check step and an update step, and the
// result appears on res_o with done_o high for exactly one cycle, once the
// update step is through. The receiver cannot stall, so nothing holds
// the result back. busy falls in the same cycle that done_o rises, so a new
// request may be taken at the edge that ends the result cycle; no new request
// is taken while one is in the check and update sequence of the controller.
// The configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
// is always ready and writes page size, entry overhead and base overhead; write
// it only while no request is in flight. Reset clears the entry count and the
// charged bytes and loads the default configuration; the entry cells keep no
// reset value, and only the cells below the entry count hold valid entries.

module sorted_distance_entry_table #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire sdet_pkg::req_t req_i,
  output logic                done_o,
  output sdet_pkg::res_t      res_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [15:0]    cfg_data_i
);
  import sdet_pkg::*;

  ctrl_cmd_t cmd;
  cfg_t      cfg;

  sdet_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sdet_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  sdet_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .cfg_i  (cfg),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

// ===== rtl/sdet_cfg.sv =====
// Configuration registers of the sorted distance entry table.
`default_nettype none

module sdet_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [15:0]   cfg_data_i,
  output sdet_pkg::cfg_t     cfg_o
);
  import sdet_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PAGE_SIZE:      cfg_d.page_size      = cfg_data_i;
        CFG_ENTRY_OVERHEAD: cfg_d.entry_overhead = cfg_data_i[7:0];
        CFG_BASE_OVERHEAD:  cfg_d.base_overhead  = cfg_data_i[9:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.page_size      <= PAGE_SIZE_RST;
      cfg_q.entry_overhead <= ENTRY_OVERHEAD_RST;
      cfg_q.base_overhead  <= BASE_OVERHEAD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/sdet_ctrl.sv =====
// Controller state machine that sequences capture, check and update of a request.
`default_nettype none
`include "sorted_distance_entry_table_defines.svh"

module sdet_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  output logic                done_o,
  output sdet_pkg::ctrl_cmd_t cmd_o
);
  import sdet_pkg::*;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start_i) state_d = S_CHECK;
      S_CHECK:  state_d = S_UPDATE;
      S_UPDATE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    done_d = 1'b0;
    unique case (state_q)
      S_IDLE:   cmd_o.capture = start_i;
      S_CHECK:  cmd_o.check   = 1'b1;
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        done_d       = 1'b1;
      end
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  `SDET_ASSERT_NEXT(a_accept_to_check, start_i && !busy_o, state_q == S_CHECK, "missed check")
  `SDET_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe lasted more than one cycle")
  `SDET_ASSERT_NOW(a_done_after_update, done_q, $past(state_q) == S_UPDATE, "stray strobe")
  `SDET_ASSERT_NOW(a_done_not_busy, done_q, !busy_o, "block busy while a result is shown")

endmodule

`default_nettype wire

// ===== rtl/sdet_datapath.sv =====
// Datapath with the sorted entry cells, byte accounting and result registers.
`default_nettype none

module sdet_datapath #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sdet_pkg::ctrl_cmd_t cmd_i,
  input  wire sdet_pkg::req_t      req_i,
  input  wire sdet_pkg::cfg_t      cfg_i,
  output sdet_pkg::res_t           res_o
);
  import sdet_pkg::*;

  localparam int CntW = $clog2(MAX_ENTRIES + 1);
  localparam int IdxW = $clog2(MAX_ENTRIES);

  req_t                   req_q;
  logic [31:0]            key_q [MAX_ENTRIES];
  logic [31:0]            key_d [MAX_ENTRIES];
  logic [15:0]            hdl_q [MAX_ENTRIES];
  logic [15:0]            hdl_d [MAX_ENTRIES];
  logic [15:0]            siz_q [MAX_ENTRIES];
  logic [15:0]            siz_d [MAX_ENTRIES];
  logic [CntW-1:0]        count_q, count_d;
  logic [15:0]            charged_q, charged_d;
  logic [MAX_ENTRIES-1:0] gt_q, gt_d, rm_q, rm_d, prev_gt;
  act_e                   act_q, act_d;
  logic [1:0]             status_q, status_d;
  logic [15:0]            obj_q, obj_d, rel_size_q, rel_size_d;
  logic [31:0]            dist_q, dist_d;
  logic [17:0]            need;
  logic                   no_room;
  logic                   del_ok;
  logic [CntW-1:0]        del_pos;
  logic [IdxW-1:0]        rd_idx;
  logic [16:0]            rel_amount;
  logic [16:0]            used_sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
  end

  // Check step: budget test, insertion mask, removal mask and entry readout.
  always_comb begin
    need    = 18'(cfg_i.base_overhead) + 18'(charged_q) + 18'(req_q.object_size)
            + 18'(cfg_i.entry_overhead);
    no_room = (count_q == CntW'(MAX_ENTRIES)) || (need > 18'(cfg_i.page_size));
    if (req_q.func == FUNC_REMOVE) begin
      del_ok  = (32'(req_q.index) < 32'(count_q));
      del_pos = CntW'(req_q.index);
    end else begin
      del_ok  = (count_q != '0);
      del_pos = count_q - 1'b1;
    end
    rd_idx = del_pos[IdxW-1:0];
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      gt_d[i] = (CntW'(i) < count_q) && (req_q.distance < key_q[i]);
      rm_d[i] = (CntW'(i) >= del_pos);
    end
    act_d      = ACT_NONE;
    status_d   = STATUS_OK;
    obj_d      = '0;
    dist_d     = '0;
    rel_size_d = siz_q[rd_idx];
    case (req_q.func)
      FUNC_ADD: begin
        if (no_room) begin
          status_d = STATUS_NO_ROOM;
        end else begin
          act_d = ACT_INSERT;
        end
      end
      FUNC_REMOVE, FUNC_POP: begin
        if (del_ok) begin
          act_d  = ACT_DELETE;
          obj_d  = hdl_q[rd_idx];
          dist_d = key_q[rd_idx];
        end else begin
          status_d = STATUS_BAD_IDX;
        end
      end
      default: act_d = ACT_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= ACT_NONE;
    end else if (cmd_i.check) begin
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      gt_q       <= gt_d;
      rm_q       <= rm_d;
      status_q   <= status_d;
      obj_q      <= obj_d;
      dist_q     <= dist_d;
      rel_size_q <= rel_size_d;
    end
  end

  // Update step: shift the cells and settle the count and charged bytes.
  always_comb begin
    prev_gt    = {gt_q[MAX_ENTRIES-2:0], 1'b0};
    rel_amount = 17'(rel_size_q) + 17'(cfg_i.entry_overhead);
    key_d      = key_q;
    hdl_d      = hdl_q;
    siz_d      = siz_q;
    count_d    = count_q;
    charged_d  = charged_q;
    case (act_q)
      ACT_INSERT: begin
        for (int i = 1; i < MAX_ENTRIES; i++) begin
          if (gt_q[i-1]) begin
            key_d[i] = key_q[i-1];
            hdl_d[i] = hdl_q[i-1];
            siz_d[i] = siz_q[i-1];
          end
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (!prev_gt[i] && (gt_q[i] || (count_q == CntW'(i)))) begin
            key_d[i] = req_q.distance;
            hdl_d[i] = req_q.object_id;
            siz_d[i] = req_q.object_size;
          end
        end
        count_d   = count_q + 1'b1;
        charged_d = charged_q + req_q.object_size + 16'(cfg_i.entry_overhead);
      end
      ACT_DELETE: begin
        for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
          if (rm_q[i]) begin
            key_d[i] = key_q[i+1];
            hdl_d[i] = hdl_q[i+1];
            siz_d[i] = siz_q[i+1];
          end
        end
        count_d   = count_q - 1'b1;
        charged_d = (rel_amount > 17'(charged_q)) ? '0 : (charged_q - rel_amount[15:0]);
      end
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      key_q <= key_d;
      hdl_q <= hdl_d;
      siz_q <= siz_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      charged_q <= '0;
    end else if (cmd_i.update) begin
      count_q   <= count_d;
      charged_q <= charged_d;
    end
  end

  assign used_sum = 17'(cfg_i.base_overhead) + 17'(charged_q);

  always_comb begin
    res_o.status       = status_q;
    res_o.out_object   = obj_q;
    res_o.out_distance = dist_q;
    res_o.entry_count  = 5'(count_q);
    res_o.used_bytes   = used_sum[16] ? 16'hFFFF : used_sum[15:0];
  end

endmodule

`default_nettype wire
